[rtl/core/cvfs_pkg.sv]
`default_nettype none

package cvfs_pkg;

  // Input kinds
  localparam logic [1:0] KIND_RX   = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_SEND = 2'd2;

  // Segment tags as seen in received data byte 0
  localparam logic [7:0] RX_SEG_1 = 8'h01;
  localparam logic [7:0] RX_SEG_2 = 8'h02;
  localparam logic [7:0] RX_SEG_3 = 8'h03;

  // Segment tags of outgoing messages
  localparam logic [1:0] TX_SEG_1 = 2'd1;
  localparam logic [1:0] TX_SEG_2 = 2'd2;
  localparam logic [1:0] TX_SEG_3 = 2'd3;

  // Result kinds
  localparam logic RESULT_MSG   = 1'b0;
  localparam logic RESULT_FRAME = 1'b1;

  localparam logic [7:0] BROADCAST = 8'hFF;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_ADDRESS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PEER_HOLD_TICKS = 1'b1;

  localparam logic [7:0]  NODE_ADDRESS_RST    = 8'd2;
  localparam logic [15:0] PEER_HOLD_TICKS_RST = 16'd3000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] rx_sender_id;
    logic [7:0]  rx_segment;
    logic [55:0] rx_body;
    logic [55:0] tx_part_a;
    logic [55:0] tx_part_b;
    logic [47:0] tx_part_c;
    logic        talk_enabled;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [10:0] tx_sender_id;
    logic [1:0]  tx_segment;
    logic [55:0] tx_body;
    logic [55:0] frame_part_a;
    logic [55:0] frame_part_b;
    logic [47:0] frame_part_c;
    logic        last;
  } out_t;

  // Status from the link state block to the output stage
  typedef struct packed {
    logic        frame_hit;
    logic [7:0]  node_address;
    logic [7:0]  peer_address;
    logic [55:0] first_store;
    logic [55:0] second_store;
  } stat_t;

  // Outgoing CAN message beat
  function automatic out_t make_msg(logic [7:0] node, logic [1:0] tag,
                                    logic [55:0] body, logic last);
    out_t m;
    m              = '0;
    m.result_kind  = RESULT_MSG;
    m.tx_sender_id = {3'b000, node};
    m.tx_segment   = tag;
    m.tx_body      = body;
    m.last         = last;
    return m;
  endfunction

endpackage

`default_nettype wire

[rtl/core/cvfs_state.sv]
`default_nettype none

module cvfs_state (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             beat_valid,
  input  wire cvfs_pkg::in_t                    beat,
  input  wire logic                             cfg_we,
  input  wire logic [cvfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cvfs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output cvfs_pkg::stat_t                       stat
);

  logic [7:0]  node_address_r, node_address_nxt;
  logic [15:0] hold_ticks_r, hold_ticks_nxt;
  logic [55:0] first_store_r, first_store_nxt;
  logic [55:0] second_store_r, second_store_nxt;
  logic [7:0]  peer_r, peer_nxt;
  logic [15:0] hold_cnt_r, hold_cnt_nxt;
  logic [7:0]  dest;
  logic        seg3;
  logic        directed;
  logic        bcast;

  // Segment 3 destination match
  assign dest     = beat.rx_body[55:48];
  assign seg3     = beat_valid && (beat.kind == cvfs_pkg::KIND_RX) &&
                    (beat.rx_segment == cvfs_pkg::RX_SEG_3);
  assign directed = seg3 && (dest == node_address_r);
  assign bcast    = seg3 && !directed && (dest == cvfs_pkg::BROADCAST);

  // Config writes
  always_comb begin
    node_address_nxt = node_address_r;
    hold_ticks_nxt   = hold_ticks_r;
    if (cfg_we) begin
      unique case (cfg_index)
        cvfs_pkg::REG_NODE_ADDRESS:    node_address_nxt = cfg_wdata[7:0];
        cvfs_pkg::REG_PEER_HOLD_TICKS: hold_ticks_nxt   = cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stores, peer and hold timer
  always_comb begin
    first_store_nxt  = first_store_r;
    second_store_nxt = second_store_r;
    peer_nxt         = peer_r;
    hold_cnt_nxt     = hold_cnt_r;
    if (beat_valid && (beat.kind == cvfs_pkg::KIND_RX)) begin
      if (beat.rx_segment == cvfs_pkg::RX_SEG_1) begin
        first_store_nxt = beat.rx_body;
      end
      if (beat.rx_segment == cvfs_pkg::RX_SEG_2) begin
        second_store_nxt = beat.rx_body;
      end
    end
    if (directed) begin
      peer_nxt     = beat.rx_sender_id[7:0];
      hold_cnt_nxt = hold_ticks_r;
    end else if (bcast) begin
      peer_nxt = cvfs_pkg::BROADCAST;
    end
    if (beat_valid && (beat.kind == cvfs_pkg::KIND_TICK)) begin
      if (hold_cnt_r != 16'd0) begin
        hold_cnt_nxt = hold_cnt_r - 16'd1;
      end else begin
        peer_nxt = cvfs_pkg::BROADCAST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_address_r <= cvfs_pkg::NODE_ADDRESS_RST;
      hold_ticks_r   <= cvfs_pkg::PEER_HOLD_TICKS_RST;
      first_store_r  <= '0;
      second_store_r <= '0;
      peer_r         <= cvfs_pkg::BROADCAST;
      hold_cnt_r     <= '0;
    end else begin
      node_address_r <= node_address_nxt;
      hold_ticks_r   <= hold_ticks_nxt;
      first_store_r  <= first_store_nxt;
      second_store_r <= second_store_nxt;
      peer_r         <= peer_nxt;
      hold_cnt_r     <= hold_cnt_nxt;
    end
  end

  assign stat.frame_hit    = directed || bcast;
  assign stat.node_address = node_address_r;
  assign stat.peer_address = peer_r;
  assign stat.first_store  = first_store_r;
  assign stat.second_store = second_store_r;

endmodule

`default_nettype wire

[rtl/core/can_voice_frame_segmenter.sv]
`default_nettype none
// The first result beat for an input appears on out_* the cycle after it is accepted.
// A send beat with talk on issues three result beats in turn, one per CAN segment;
// every other input beat issues at most one.
// Input is held off while segments 2 and 3 of a send are still being issued.
// Reset (synchronous, rst_n low): registers to defaults, stores cleared, peer broadcast.

module can_voice_frame_segmenter (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire cvfs_pkg::in_t                    in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output cvfs_pkg::out_t                        out_data,
  input  wire logic                             cfg_we,
  input  wire logic [cvfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cvfs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  cvfs_pkg::stat_t stat;
  cvfs_pkg::out_t  out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            pend_r, pend_nxt;
  logic [1:0]      pend_tag_r, pend_tag_nxt;
  logic [55:0]     pend_b_r, pend_b_nxt;
  logic [55:0]     pend_c_r, pend_c_nxt;
  logic            can_load;
  logic            in_beat;
  logic            send_go;

  assign can_load = !out_valid_r || out_ready;
  assign in_ready = can_load && !pend_r;
  assign in_beat  = in_valid && in_ready;
  assign send_go  = in_beat && (in_data.kind == cvfs_pkg::KIND_SEND) && in_data.talk_enabled;

  cvfs_state u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (in_beat),
    .beat       (in_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .stat       (stat)
  );

  // Output register load: pending segments first, then new beats
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    pend_nxt      = pend_r;
    pend_tag_nxt  = pend_tag_r;
    pend_b_nxt    = pend_b_r;
    pend_c_nxt    = pend_c_r;
    if (can_load) begin
      out_valid_nxt = 1'b0;
      if (pend_r) begin
        out_valid_nxt = 1'b1;
        if (pend_tag_r == cvfs_pkg::TX_SEG_2) begin
          out_nxt      = cvfs_pkg::make_msg(stat.node_address, cvfs_pkg::TX_SEG_2,
                                            pend_b_r, 1'b0);
          pend_tag_nxt = cvfs_pkg::TX_SEG_3;
        end else begin
          out_nxt  = cvfs_pkg::make_msg(stat.node_address, cvfs_pkg::TX_SEG_3,
                                        pend_c_r, 1'b1);
          pend_nxt = 1'b0;
        end
      end else if (send_go) begin
        out_valid_nxt = 1'b1;
        out_nxt       = cvfs_pkg::make_msg(stat.node_address, cvfs_pkg::TX_SEG_1,
                                           in_data.tx_part_a, 1'b0);
        pend_nxt      = 1'b1;
        pend_tag_nxt  = cvfs_pkg::TX_SEG_2;
        pend_b_nxt    = in_data.tx_part_b;
        pend_c_nxt    = {stat.peer_address, in_data.tx_part_c};
      end else if (stat.frame_hit) begin
        out_valid_nxt        = 1'b1;
        out_nxt              = '0;
        out_nxt.result_kind  = cvfs_pkg::RESULT_FRAME;
        out_nxt.frame_part_a = stat.first_store;
        out_nxt.frame_part_b = stat.second_store;
        out_nxt.frame_part_c = in_data.rx_body[47:0];
        out_nxt.last         = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      pend_tag_r  <= cvfs_pkg::TX_SEG_2;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      pend_tag_r  <= pend_tag_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    out_r    <= out_nxt;
    pend_b_r <= pend_b_nxt;
    pend_c_r <= pend_c_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

[tb/can_voice_frame_segmenter_test.sv]
module can_voice_frame_segmenter_test;
  import cvfs_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;

  // Input kind with no defined meaning
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  can_voice_frame_segmenter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mirror of the link state: config, reassembly stores, peer and hold timer
  logic [7:0] node_addr;
  logic [15:0] hold_ticks;
  logic [55:0] first_store;
  logic [55:0] second_store;
  logic [7:0] peer_addr;
  logic [15:0] hold_left;

  out_t expected_beats[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  int unsigned stall_left = 0;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [55:0] rand56();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[55:0];
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[47:0];
  endfunction

  function automatic out_t can_msg(logic [1:0] tag, logic [55:0] body, logic fin);
    out_t m;
    m = '0;
    m.result_kind = RESULT_MSG;
    m.tx_sender_id = {3'b000, node_addr};
    m.tx_segment = tag;
    m.tx_body = body;
    m.last = fin;
    return m;
  endfunction

  // Segment outgoing frames, reassemble incoming ones, track the peer
  function automatic void predict_item(in_t it);
    logic [7:0] dest;
    out_t f;
    dest = it.rx_body[55:48];
    f = '0;
    f.result_kind = RESULT_FRAME;
    f.last = 1'b1;
    case (it.kind)
      KIND_RX: begin
        case (it.rx_segment)
          RX_SEG_1: first_store = it.rx_body;
          RX_SEG_2: second_store = it.rx_body;
          RX_SEG_3: begin
            f.frame_part_a = first_store;
            f.frame_part_b = second_store;
            f.frame_part_c = it.rx_body[47:0];
            if (dest == node_addr) begin
              peer_addr = it.rx_sender_id[7:0];
              hold_left = hold_ticks;
              expected_beats.push_back(f);
            end else if (dest == BROADCAST) begin
              peer_addr = BROADCAST;
              expected_beats.push_back(f);
            end
          end
          default: ;
        endcase
      end
      KIND_TICK: begin
        if (hold_left != 0) hold_left = hold_left - 16'd1;
        else peer_addr = BROADCAST;
      end
      KIND_SEND: begin
        if (it.talk_enabled) begin
          expected_beats.push_back(can_msg(TX_SEG_1, it.tx_part_a, 1'b0));
          expected_beats.push_back(can_msg(TX_SEG_2, it.tx_part_b, 1'b0));
          expected_beats.push_back(can_msg(TX_SEG_3, {peer_addr, it.tx_part_c}, 1'b1));
        end
      end
      default: ;
    endcase
  endfunction

  // Item builders: unused fields stay random
  function automatic in_t random_item();
    in_t it;
    it.kind = 2'($urandom_range(3));
    it.rx_sender_id = 11'($urandom());
    it.rx_segment = 8'($urandom());
    it.rx_body = rand56();
    it.tx_part_a = rand56();
    it.tx_part_b = rand56();
    it.tx_part_c = rand48();
    it.talk_enabled = 1'($urandom());
    return it;
  endfunction

  function automatic in_t mk_rx(logic [10:0] sender, logic [7:0] seg, logic [55:0] body);
    in_t it;
    it = random_item();
    it.kind = KIND_RX;
    it.rx_sender_id = sender;
    it.rx_segment = seg;
    it.rx_body = body;
    return it;
  endfunction

  function automatic in_t mk_tick();
    in_t it;
    it = random_item();
    it.kind = KIND_TICK;
    return it;
  endfunction

  function automatic in_t mk_send(logic [55:0] a, logic [55:0] b, logic [47:0] c,
                                  logic talk);
    in_t it;
    it = random_item();
    it.kind = KIND_SEND;
    it.tx_part_a = a;
    it.tx_part_b = b;
    it.tx_part_c = c;
    it.talk_enabled = talk;
    return it;
  endfunction

  // Offer one beat, predict on acceptance; valid stays up when no gap follows
  task automatic send_item(in_t it);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict_item(it);
    items_sent++;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender until every expected result is out, plus settling time
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(logic [15:0] node_val, logic [15:0] hold_val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_NODE_ADDRESS;
    cfg_wdata <= node_val;
    @(posedge clk);
    node_addr = node_val[7:0];
    cfg_index <= REG_PEER_HOLD_TICKS;
    cfg_wdata <= hold_val;
    @(posedge clk);
    hold_ticks = hold_val;
    cfg_we <= 1'b0;
  endtask

  function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at %0t: %s expected %h got %h", $time, what, want, got);
  endfunction

  task automatic check_beat(out_t got);
    out_t want;
    if (expected_beats.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat at %0t: %h", $time, got);
      return;
    end
    want = expected_beats.pop_front();
    if (got.result_kind !== want.result_kind)
      note_mismatch("result_kind", 64'(want.result_kind), 64'(got.result_kind));
    if (got.tx_sender_id !== want.tx_sender_id)
      note_mismatch("tx_sender_id", 64'(want.tx_sender_id), 64'(got.tx_sender_id));
    if (got.tx_segment !== want.tx_segment)
      note_mismatch("tx_segment", 64'(want.tx_segment), 64'(got.tx_segment));
    if (got.tx_body !== want.tx_body)
      note_mismatch("tx_body", 64'(want.tx_body), 64'(got.tx_body));
    if (got.frame_part_a !== want.frame_part_a)
      note_mismatch("frame_part_a", 64'(want.frame_part_a), 64'(got.frame_part_a));
    if (got.frame_part_b !== want.frame_part_b)
      note_mismatch("frame_part_b", 64'(want.frame_part_b), 64'(got.frame_part_b));
    if (got.frame_part_c !== want.frame_part_c)
      note_mismatch("frame_part_c", 64'(want.frame_part_c), 64'(got.frame_part_c));
    if (got.last !== want.last)
      note_mismatch("last", 64'(want.last), 64'(got.last));
  endtask

  // Result side: check each beat, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_beat(out_data);
    if (!stalls_on) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(99) < 25) begin
      stall_left = pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: too long without any beat moving
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Reset values, a frame sent and one received with a wide sender id
  task automatic test_defaults();
    send_item(mk_send('1, '1, '1, 1'b1));
    send_item(mk_rx(11'h400, RX_SEG_1, '0));
    send_item(mk_rx(11'h000, RX_SEG_2, '1));
    send_item(mk_rx(11'h7AB, RX_SEG_3, {8'd2, 48'h123456789ABC}));
    send_item(mk_send('0, '0, '0, 1'b1));
  endtask

  task automatic test_special_cases();
    in_t it;
    it = random_item();
    it.kind = KIND_UNKNOWN;
    send_item(it);
    send_item(mk_send(rand56(), rand56(), rand48(), 1'b0));
    send_item(mk_rx(11'h011, 8'h00, rand56()));
    send_item(mk_rx(11'h022, 8'h04, rand56()));
    send_item(mk_rx(11'h033, 8'hFF, rand56()));
    // foreign destination leaves everything alone
    send_item(mk_rx(11'h044, RX_SEG_3, {8'h55, 48'hFFFFFFFFFFFF}));
    // broadcast frame drops the peer back to broadcast
    send_item(mk_rx(11'h123, RX_SEG_3, {BROADCAST, 48'h0}));
    send_item(mk_send(rand56(), rand56(), rand48(), 1'b1));
    // segment 3 with no fresh segments 1 and 2
    send_item(mk_rx(11'h7FF, RX_SEG_3, {8'd2, 48'hA5A5A5A5A5A5}));
  endtask

  task automatic test_hold_timer();
    write_config(16'h0010, 16'd2);
    send_item(mk_rx(11'h035, RX_SEG_3, {8'h10, 48'h1}));
    send_item(mk_tick());
    send_item(mk_tick());
    send_item(mk_send(rand56(), rand56(), rand48(), 1'b1));
    send_item(mk_tick());
    send_item(mk_send(rand56(), rand56(), rand48(), 1'b1));
    // node 255: a broadcast frame takes the directed path
    write_config(16'hFFFF, 16'd0);
    send_item(mk_rx(11'h542, RX_SEG_3, {BROADCAST, 48'h2}));
    send_item(mk_send(rand56(), rand56(), rand48(), 1'b1));
    send_item(mk_tick());
    send_item(mk_send(rand56(), rand56(), rand48(), 1'b1));
  endtask

  // Mostly well-formed traffic with random content, some noise
  task automatic test_random_traffic(int unsigned n, logic [15:0] node_val,
                                     logic [15:0] hold_val);
    int unsigned start;
    int unsigned r;
    int unsigned ticks;
    logic [7:0] dest;
    logic [10:0] sender;
    write_config(node_val, hold_val);
    start = items_sent;
    while (items_sent - start < n) begin
      r = $urandom_range(99);
      if (r < 30) begin
        send_item(mk_send(rand56(), rand56(), rand48(), $urandom_range(9) != 0));
      end else if (r < 65) begin
        sender = 11'($urandom());
        case ($urandom_range(3))
          0, 1: dest = node_addr;
          2: dest = BROADCAST;
          default: dest = 8'($urandom());
        endcase
        if ($urandom_range(99) < 80) begin
          send_item(mk_rx(sender, RX_SEG_1, rand56()));
          send_item(mk_rx(sender, RX_SEG_2, rand56()));
        end
        send_item(mk_rx(sender, RX_SEG_3, {dest, rand48()}));
      end else if (r < 80) begin
        ticks = (hold_ticks < 8) ? $urandom_range(hold_ticks + 2, 1) : $urandom_range(6, 1);
        repeat (ticks) send_item(mk_tick());
      end else if (r < 97) begin
        send_item(random_item());
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    node_addr = NODE_ADDRESS_RST;
    hold_ticks = PEER_HOLD_TICKS_RST;
    first_store = '0;
    second_store = '0;
    peer_addr = BROADCAST;
    hold_left = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_defaults();
    test_special_cases();
    test_hold_timer();
    test_random_traffic(100, 16'h0000, 16'h0000);
    test_random_traffic(100, 16'h00FF, 16'hFFFF);
    // back to back, no idling on either side
    drain();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    test_random_traffic(80, 16'($urandom()), 16'($urandom_range(6)));
    drain();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    test_random_traffic(120, 16'($urandom()), 16'($urandom_range(40)));

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/cvfs_pkg.sv
rtl/core/cvfs_state.sv
rtl/core/can_voice_frame_segmenter.sv
tb/can_voice_frame_segmenter_test.sv
